// File: src/overwriting_error_log_ring_macros.svh
// Assertion macros for the error log ring checker.
`ifndef OVERWRITING_ERROR_LOG_RING_MACROS_SVH
`define OVERWRITING_ERROR_LOG_RING_MACROS_SVH

// Assertion that is switched off while reset is high.
`define OELR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("error log ring assertion failed");

// Assertion that also holds across reset.
`define OELR_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("error log ring reset assertion failed");

`endif

// File: src/oelr_pkg.sv
// Types and codes shared by the error log ring modules.
`default_nettype none

package oelr_pkg;

   // Request kinds carried in req_type.
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } oelr_req_kind_type;

   // One input transaction.
   typedef struct packed {
      logic        req_type;
      logic [63:0] time_stamp;
      logic [31:0] error_code_in;
      logic [63:0] error_word_in;
   } oelr_req_type;

   // One result transaction.
   typedef struct packed {
      logic        entry_valid;
      logic        is_overflow;
      logic [63:0] time_out;
      logic [31:0] error_code_out;
      logic [63:0] error_word_out;
   } oelr_rsp_type;

   // One stored ring entry (also used for the overflow record).
   typedef struct packed {
      logic [63:0] time_stamp;
      logic [31:0] fault_code;
      logic [63:0] error_word;
   } oelr_entry_type;

   // Response control from the pointer logic to the output stage.
   typedef struct packed {
      logic valid;
      logic entry_valid;
      logic is_overflow;
   } oelr_rsp_ctl_type;

endpackage

`default_nettype wire

// File: src/oelr_ring_mem.sv
// Ring storage: one write port, one synchronous read port.
`default_nettype none

module oelr_ring_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                    clock,
   input  wire logic                    wr_en,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire oelr_pkg::oelr_entry_type wr_data,
   input  wire logic                    rd_en,
   input  wire logic [AW-1:0]           rd_addr,
   output oelr_pkg::oelr_entry_type     rd_data
);

   oelr_pkg::oelr_entry_type mem_ff [DEPTH];
   oelr_pkg::oelr_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/oelr_ctrl.sv
// Write/read counts, slot pointers, overflow register and response control.
`default_nettype none

module oelr_ctrl #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire oelr_pkg::oelr_req_type   req,
   input  wire logic                     csr_write,
   input  wire logic [31:0]              csr_data,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output oelr_pkg::oelr_entry_type      wr_data,
   output logic                          rd_en,
   output logic [AW-1:0]                 rd_addr,
   output oelr_pkg::oelr_rsp_ctl_type    rsp_ctl,
   output oelr_pkg::oelr_entry_type      ovf_rec
);

   // 2^32 mod DEPTH: slot offset picked up when a count wraps below zero
   localparam int unsigned WRAP_OFS = int'((64'd1 << 32) % DEPTH);
   localparam logic [31:0] DEPTH32  = 32'(DEPTH);

   logic [31:0]               writes_ff, writes_in;
   logic [31:0]               reads_ff, reads_in;
   logic [AW-1:0]             wr_slot_ff, wr_slot_in;
   logic [AW-1:0]             rd_slot_ff, rd_slot_in;
   logic [31:0]               ovf_code_ff;
   oelr_pkg::oelr_rsp_ctl_type rsp_ctl_ff, rsp_ctl_in;
   oelr_pkg::oelr_entry_type  ovf_rec_ff;

   logic [31:0]   diff;
   logic          is_empty;
   logic          is_lost;
   logic          is_write;
   logic          is_read;
   logic [AW:0]   lost_sum;
   logic [AW-1:0] lost_slot;

   // next slot for a count step; a 32-bit count wrap restarts at slot zero
   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] slot,
                                                input logic [31:0] count);
      logic [AW-1:0] nxt;
      if (count == '1 || slot == AW'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

   assign is_write = accept && (req.req_type == oelr_pkg::REQ_WRITE);
   assign is_read  = accept && (req.req_type == oelr_pkg::REQ_READ);
   assign diff     = writes_ff - reads_ff;
   assign is_empty = (diff == '0);
   assign is_lost  = (diff > DEPTH32);

   // slot of writes - DEPTH; adds 2^32 mod DEPTH when that subtraction wraps
   assign lost_sum = {1'b0, wr_slot_ff} + (AW+1)'(WRAP_OFS);
   always_comb begin
      if (writes_ff >= DEPTH32) begin
         lost_slot = wr_slot_ff;
      end else if (lost_sum >= (AW+1)'(DEPTH)) begin
         lost_slot = AW'(lost_sum - (AW+1)'(DEPTH));
      end else begin
         lost_slot = lost_sum[AW-1:0];
      end
   end

   // next state of counts and pointers
   always_comb begin
      writes_in  = writes_ff;
      wr_slot_in = wr_slot_ff;
      reads_in   = reads_ff;
      rd_slot_in = rd_slot_ff;
      rsp_ctl_in.valid       = is_read;
      rsp_ctl_in.entry_valid = !is_empty;
      rsp_ctl_in.is_overflow = is_lost;
      if (is_write) begin
         writes_in  = writes_ff + 1'b1;
         wr_slot_in = next_slot(wr_slot_ff, writes_ff);
      end
      if (is_read && !is_empty) begin
         if (is_lost) begin
            reads_in   = writes_ff - DEPTH32;
            rd_slot_in = lost_slot;
         end else begin
            reads_in   = reads_ff + 1'b1;
            rd_slot_in = next_slot(rd_slot_ff, reads_ff);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         writes_ff   <= '0;
         reads_ff    <= '0;
         wr_slot_ff  <= '0;
         rd_slot_ff  <= '0;
         ovf_code_ff <= '0;
         rsp_ctl_ff  <= '0;
      end else begin
         writes_ff  <= writes_in;
         reads_ff   <= reads_in;
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         rsp_ctl_ff <= rsp_ctl_in;
         if (csr_write) begin
            ovf_code_ff <= csr_data;
         end
      end
   end

   // overflow record payload, captured with the read
   always_ff @(posedge clock) begin
      if (is_read) begin
         ovf_rec_ff.time_stamp <= req.time_stamp;
         ovf_rec_ff.fault_code <= ovf_code_ff;
         ovf_rec_ff.error_word <= {32'd0, diff - DEPTH32};
      end
   end

   // memory port drive
   assign wr_en   = is_write;
   assign wr_addr = wr_slot_ff;
   assign wr_data.time_stamp = req.time_stamp;
   assign wr_data.fault_code = req.error_code_in;
   assign wr_data.error_word = req.error_word_in;
   assign rd_en   = is_read && !is_empty && !is_lost;
   assign rd_addr = rd_slot_ff;
   assign rsp_ctl = rsp_ctl_ff;
   assign ovf_rec = ovf_rec_ff;

endmodule

`default_nettype wire

// File: src/overwriting_error_log_ring.sv
// A read transaction's result is on rsp in the cycle after it is accepted;
// a write transaction gives no result and is stored at its accepting edge.
// Throughput: one transaction per cycle while busy is low, set by the single ring memory port pair.
// busy is high only while reset is high; the receiver cannot stall results.
// Synchronous reset clears both counts and the overflow code; ring entries
// stay undefined until written, and no clearing pass is run.
`default_nettype none

module overwriting_error_log_ring #(
   parameter int RING_DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire oelr_pkg::oelr_req_type req_data,
   output logic                        rsp_valid,
   output oelr_pkg::oelr_rsp_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [31:0]            csr_data
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic                       accept;
   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   oelr_pkg::oelr_entry_type   wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   oelr_pkg::oelr_entry_type   rd_data;
   oelr_pkg::oelr_rsp_ctl_type rsp_ctl;
   oelr_pkg::oelr_entry_type   ovf_rec;

   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   oelr_ctrl #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rsp_ctl   (rsp_ctl),
      .ovf_rec   (ovf_rec)
   );

   oelr_ring_mem #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result select: empty reads give zeros
   assign rsp_valid = rsp_ctl.valid;
   always_comb begin
      rsp_data.entry_valid = rsp_ctl.entry_valid;
      rsp_data.is_overflow = rsp_ctl.entry_valid && rsp_ctl.is_overflow;
      priority if (!rsp_ctl.entry_valid) begin
         rsp_data.time_out       = '0;
         rsp_data.error_code_out = '0;
         rsp_data.error_word_out = '0;
      end else if (rsp_ctl.is_overflow) begin
         rsp_data.time_out       = ovf_rec.time_stamp;
         rsp_data.error_code_out = ovf_rec.fault_code;
         rsp_data.error_word_out = ovf_rec.error_word;
      end else begin
         rsp_data.time_out       = rd_data.time_stamp;
         rsp_data.error_code_out = rd_data.fault_code;
         rsp_data.error_word_out = rd_data.error_word;
      end
   end

endmodule

`default_nettype wire

// File: src/oelr_checker.sv
// Port-level checker for the error log ring, bound to the top level.
`default_nettype none
`include "overwriting_error_log_ring_macros.svh"

module oelr_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire oelr_pkg::oelr_req_type req,
   input wire logic                   rsp_valid,
   input wire oelr_pkg::oelr_rsp_type rsp
);

   logic read_acc;
   logic write_acc;

   assign read_acc  = start && !busy && (req.req_type == oelr_pkg::REQ_READ);
   assign write_acc = start && !busy && (req.req_type == oelr_pkg::REQ_WRITE);

   // each accepted read gives exactly one result in the next cycle
   `OELR_ASSERT(a_read_gives_rsp, read_acc |=> rsp_valid)
   `OELR_ASSERT(a_rsp_from_read, rsp_valid |-> $past(read_acc))
   // a write transaction never gives a result
   `OELR_ASSERT(a_write_no_rsp, write_acc |=> !rsp_valid)
   // empty result carries all zeros
   `OELR_ASSERT(a_empty_zero, (rsp_valid && !rsp.entry_valid) |-> (!rsp.is_overflow &&
      rsp.time_out == '0 && rsp.error_code_out == '0 && rsp.error_word_out == '0))
   // reset drops any pending result
   `OELR_ASSERT_RST(a_reset_clears, reset |=> !rsp_valid)

endmodule

bind overwriting_error_log_ring oelr_checker u_oelr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req_data),
   .rsp_valid (rsp_valid),
   .rsp       (rsp_data)
);

`default_nettype wire

// File: tb/tb_overwriting_error_log_ring.sv
// Self-checking testbench for the overwriting error log ring.
`timescale 1ns / 1ps

module tb_overwriting_error_log_ring;

   localparam int unsigned RING_DEPTH = 64;
   localparam int unsigned QUIET_LIMIT = 1000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   oelr_pkg::oelr_req_type req_bus;
   logic                   rsp_valid;
   oelr_pkg::oelr_rsp_type rsp_bus;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [31:0]            csr_data;

   // Shadow copy of the ring, counts and overflow code
   logic [63:0]   ring_times [RING_DEPTH];
   logic [31:0]   ring_codes [RING_DEPTH];
   logic [63:0]   ring_words [RING_DEPTH];
   logic [31:0]   writes_done;
   logic [31:0]   reads_done;
   logic [31:0]   lost_record_code;

   oelr_pkg::oelr_rsp_type pending_records [$];
   int            failures;
   int            items_sent;
   int            writes_seen;
   int            reads_seen;
   int            empty_count;
   int            lost_count;
   int            quiet_cycles;
   int            sender_gap_pct;

   overwriting_error_log_ring #(.RING_DEPTH(RING_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_bus),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic oelr_pkg::oelr_req_type make_req(oelr_pkg::oelr_req_kind_type kind,
                                                       logic [63:0] stamp,
                                                       logic [31:0] code,
                                                       logic [63:0] word);
      oelr_pkg::oelr_req_type item;
      item.req_type      = kind;
      item.time_stamp    = stamp;
      item.error_code_in = code;
      item.error_word_in = word;
      return item;
   endfunction

   // Applies one transaction to the shadow ring; returns 1 when a record is due
   function automatic bit log_ring_access(input oelr_pkg::oelr_req_type item,
                                          output oelr_pkg::oelr_rsp_type rec);
      logic [31:0] unread;
      logic [31:0] slot;
      rec = '0;
      if (item.req_type == oelr_pkg::REQ_WRITE) begin
         slot = writes_done % RING_DEPTH;
         ring_times[slot] = item.time_stamp;
         ring_codes[slot] = item.error_code_in;
         ring_words[slot] = item.error_word_in;
         writes_done = writes_done + 32'd1;
         writes_seen++;
         return 1'b0;
      end
      reads_seen++;
      unread = writes_done - reads_done;
      if (unread == 32'd0) begin
         empty_count++;
      end else if (unread > RING_DEPTH) begin
         // entries were overwritten before being read
         rec.entry_valid    = 1'b1;
         rec.is_overflow    = 1'b1;
         rec.time_out       = item.time_stamp;
         rec.error_code_out = lost_record_code;
         rec.error_word_out = {32'd0, unread - 32'(RING_DEPTH)};
         reads_done = writes_done - 32'(RING_DEPTH);
         lost_count++;
      end else begin
         slot = reads_done % RING_DEPTH;
         rec.entry_valid    = 1'b1;
         rec.time_out       = ring_times[slot];
         rec.error_code_out = ring_codes[slot];
         rec.error_word_out = ring_words[slot];
         reads_done = reads_done + 32'd1;
      end
      return 1'b1;
   endfunction

   // Prediction and checking, all at the rising edge
   always @(posedge clock) begin
      oelr_pkg::oelr_rsp_type want;
      oelr_pkg::oelr_rsp_type rec;
      if (reset) begin
         writes_done      = '0;
         reads_done       = '0;
         lost_record_code = '0;
         pending_records.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_records.size() == 0) begin
               failures++;
               $error("result transaction with no read waiting");
            end else begin
               want = pending_records.pop_front();
               if (rsp_bus.entry_valid !== want.entry_valid) begin
                  failures++;
                  $error("entry_valid: expected %0b, got %0b",
                         want.entry_valid, rsp_bus.entry_valid);
               end
               if (rsp_bus.is_overflow !== want.is_overflow) begin
                  failures++;
                  $error("is_overflow: expected %0b, got %0b",
                         want.is_overflow, rsp_bus.is_overflow);
               end
               if (rsp_bus.time_out !== want.time_out) begin
                  failures++;
                  $error("time_out: expected %h, got %h", want.time_out, rsp_bus.time_out);
               end
               if (rsp_bus.error_code_out !== want.error_code_out) begin
                  failures++;
                  $error("error_code_out: expected %h, got %h",
                         want.error_code_out, rsp_bus.error_code_out);
               end
               if (rsp_bus.error_word_out !== want.error_word_out) begin
                  failures++;
                  $error("error_word_out: expected %h, got %h",
                         want.error_word_out, rsp_bus.error_word_out);
               end
            end
         end
         if (start && !busy) begin
            if (log_ring_access(req_bus, rec)) pending_records.push_back(rec);
         end
         if (csr_valid && csr_ready) lost_record_code = csr_data;
      end
   end

   // Watchdog: ends the run after too long with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL overwriting_error_log_ring");
         $finish;
      end
   end

   // Sends one transaction; called at a rising edge, returns at the accepting edge
   task automatic send_item(input oelr_pkg::oelr_req_type item);
      // each idle cycle is taken with the configured chance
      while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start   <= 1'b1;
      req_bus <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Stops sending and waits until every record has come back
   task automatic drain_ring_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_records.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_overflow_code(input logic [31:0] code);
      drain_ring_results();
      csr_valid <= 1'b1;
      csr_data  <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_writes(input int count);
      repeat (count) begin
         send_item(make_req(oelr_pkg::REQ_WRITE, rand_word(), $urandom, rand_word()));
      end
   endtask

   task automatic send_random_reads(input int count);
      repeat (count) begin
         send_item(make_req(oelr_pkg::REQ_READ, rand_word(), $urandom, rand_word()));
      end
   endtask

   // Reads of an empty ring right after reset, with the reset overflow code
   task automatic test_empty_after_reset();
      send_item(make_req(oelr_pkg::REQ_READ, '1, '1, '1));
      send_item(make_req(oelr_pkg::REQ_READ, '0, '0, '0));
   endtask

   // Field extremes stored and read back in order, an empty read, then one more write and read
   task automatic test_field_extremes();
      write_overflow_code(32'h0000_0000);
      send_item(make_req(oelr_pkg::REQ_WRITE, '1, '1, '1));
      send_item(make_req(oelr_pkg::REQ_WRITE, '0, '0, '0));
      send_item(make_req(oelr_pkg::REQ_WRITE, {32{2'b10}}, {16{2'b10}}, {32{2'b01}}));
      send_item(make_req(oelr_pkg::REQ_WRITE, {32{2'b01}}, {16{2'b01}}, {32{2'b10}}));
      send_item(make_req(oelr_pkg::REQ_READ, '0, '0, '0));
      send_item(make_req(oelr_pkg::REQ_READ, '1, '1, '1));
      send_item(make_req(oelr_pkg::REQ_READ, '0, '1, '0));
      send_item(make_req(oelr_pkg::REQ_READ, '1, '0, '1));
      send_item(make_req(oelr_pkg::REQ_READ, '1, '1, '1));
      send_item(make_req(oelr_pkg::REQ_WRITE, 64'h1, 32'h1, 64'h1));
      send_item(make_req(oelr_pkg::REQ_READ, 64'h8000_0000_0000_0000, '0, '0));
   endtask

   // Exactly full ring, one entry lost, and a deep overrun
   task automatic test_full_boundary();
      write_overflow_code(32'hFFFF_FFFF);
      send_random_writes(RING_DEPTH);
      send_random_reads(RING_DEPTH + 1);
      send_random_writes(RING_DEPTH + 1);
      send_item(make_req(oelr_pkg::REQ_READ, '1, '0, '0));
      send_random_reads(2);
      write_overflow_code(32'h8000_0001);
      send_random_writes(3 * RING_DEPTH + 5);
      send_item(make_req(oelr_pkg::REQ_READ, '0, '1, '1));
      send_random_reads(RING_DEPTH + 1);
   endtask

   // Mostly write bursts followed by read bursts, with some single noise items
   task automatic test_random_traffic(input int gap_pct, input int count,
                                      input logic [31:0] code);
      int stop_at;
      int writes;
      write_overflow_code(code);
      sender_gap_pct = gap_pct;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(9) < 7) begin
            writes = ($urandom_range(3) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 20);
            send_random_writes(writes);
            send_random_reads(($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                                       : $urandom_range(1, 24));
         end else if ($urandom_range(1)) begin
            send_random_reads(1);
         end else begin
            send_random_writes(1);
         end
      end
      sender_gap_pct = 0;
   endtask

   initial begin
      failures       = 0;
      items_sent     = 0;
      writes_seen    = 0;
      reads_seen     = 0;
      empty_count    = 0;
      lost_count     = 0;
      sender_gap_pct = 0;
      quiet_cycles   = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_bus   <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_after_reset();
      test_field_extremes();
      test_full_boundary();
      test_random_traffic(0, 460, 32'hFFFF_FFFF);
      test_random_traffic(68, 460, $urandom);
      test_random_traffic(33, 460, 32'h0000_0000);
      drain_ring_results();
      repeat (4) @(posedge clock);

      $display("Covered %0d transactions: %0d writes, %0d reads", items_sent, writes_seen,
               reads_seen);
      $display("Reads returned %0d empty and %0d lost-entry records", empty_count, lost_count);
      if (failures == 0) begin
         $display("PASS overwriting_error_log_ring");
      end else begin
         $display("FAIL overwriting_error_log_ring");
      end
      $finish;
   end

endmodule
